// ----- hw/rtl/rfa_pkg.sv -----
// Shared constants, codes and divider request/response types for the rational fraction ALU.
package rfa_pkg;

  localparam int IN_WIDTH  = 16;
  localparam int MAG_W     = 2 * IN_WIDTH;
  localparam int NUM_W     = 33;
  localparam int DEN_W     = 31;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int EXT_W     = (MAG_W + 1 > NUM_W) ? MAG_W + 1 : NUM_W;
  localparam int K_W       = $clog2(MAG_W);
  localparam int DIV_CNT_W = $clog2(MAG_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_DEN = 2'd1,
    STATUS_DIV_ZERO = 2'd2
  } status_e;

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic start;
    mag_t dividend_a;
    mag_t dividend_b;
    mag_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    mag_t quot_a;
    mag_t quot_b;
  } div_rsp_t;

endpackage

// ----- hw/rtl/rfa_in_if.sv -----
// Input channel: operation and two signed fractions with valid/ready.
interface rfa_in_if;
  logic                                valid;
  logic                                ready;
  logic        [rfa_pkg::CMD_W-1:0]    cmd;
  logic signed [rfa_pkg::IN_WIDTH-1:0] num_a;
  logic signed [rfa_pkg::IN_WIDTH-1:0] den_a;
  logic signed [rfa_pkg::IN_WIDTH-1:0] num_b;
  logic signed [rfa_pkg::IN_WIDTH-1:0] den_b;

  modport source (output valid, cmd, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, cmd, num_a, den_a, num_b, den_b, output ready);
endinterface

// ----- hw/rtl/rfa_out_if.sv -----
// Output channel: reduced fraction and status with valid/ready.
interface rfa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rfa_pkg::NUM_W-1:0]  num_out;
  logic        [rfa_pkg::DEN_W-1:0]  den_out;
  logic        [rfa_pkg::STAT_W-1:0] status;

  modport source (output valid, num_out, den_out, status, input ready);
  modport sink   (input valid, num_out, den_out, status, output ready);
endinterface

// ----- hw/rtl/rfa_div.sv -----
// Dual restoring divider: two dividends by one shared divisor, one quotient bit per cycle.
module rfa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rfa_pkg::div_req_t req_i,
  output rfa_pkg::div_rsp_t rsp_o
);

  localparam int W = rfa_pkg::MAG_W;

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [rfa_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  rfa_pkg::mag_t                   ra_q, ra_d, rb_q, rb_d;
  rfa_pkg::mag_t                   qa_q, qa_d, qb_q, qb_d;
  rfa_pkg::mag_t                   d_q, d_d;

  logic [W:0] sha, shb, tra, trb;
  logic       take_a, take_b;

  always_comb begin
    sha    = {ra_q, qa_q[W-1]};
    shb    = {rb_q, qb_q[W-1]};
    tra    = sha - {1'b0, d_q};
    trb    = shb - {1'b0, d_q};
    take_a = !tra[W];
    take_b = !trb[W];

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    ra_d   = ra_q;
    rb_d   = rb_q;
    qa_d   = qa_q;
    qb_d   = qb_q;
    d_d    = d_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      ra_d   = '0;
      rb_d   = '0;
      qa_d   = req_i.dividend_a;
      qb_d   = req_i.dividend_b;
      d_d    = req_i.divisor;
    end else if (busy_q) begin
      // shift in the next dividend bit, keep the difference when it fits
      ra_d = take_a ? tra[W-1:0] : sha[W-1:0];
      rb_d = take_b ? trb[W-1:0] : shb[W-1:0];
      qa_d = {qa_q[W-2:0], take_a};
      qb_d = {qb_q[W-2:0], take_b};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == rfa_pkg::DIV_CNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q <= ra_d;
    rb_q <= rb_d;
    qa_q <= qa_d;
    qb_q <= qb_d;
    d_q  <= d_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quot_a = qa_q;
  assign rsp_o.quot_b = qb_q;

  // the sequencer never restarts a running division
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  // the divisor is a common divisor, so both divisions are exact
  a_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (ra_q == '0) && (rb_q == '0))
    else $error("divisor does not divide both operands");

endmodule

// ----- hw/rtl/rational_fraction_alu.sv -----
// Top level of the rational fraction ALU: sequencer, shared multiplier and binary gcd.
//
// Usage:
//   in_i  carries cmd (add, subtract, multiply, divide) and two signed fractions
//         num_a/den_a and num_b/den_b. A beat is taken when valid and ready are high.
//   out_o carries the reduced result num_out/den_out (sign on the numerator,
//         positive denominator, zero given as 0/1) and a status code. A zero input
//         denominator or a divide by a zero fraction gives 0/0 with a nonzero status.
//   One item is worked on at a time; in_i.ready is high only while the sequencer
//   is idle. From accept to out_o.valid an item passes the multiplier states (MUL2
//   only for add and subtract), a combine state, the binary gcd steps (one
//   subtract or shift per cycle), then the divider that reduces both terms by
//   the gcd. Error cases go straight to the output; zero results skip the gcd and divider.
//   The result sits in an output register: a new beat is accepted while it waits,
//   and the sequencer holds its next result until the receiver takes the old one.
//   Reset clears the sequencer and drops any pending result; no memory to clear.
module rational_fraction_alu (
  input logic       clk_i,
  input logic       rst_ni,
  rfa_in_if.sink    in_i,
  rfa_out_if.source out_o
);

  localparam int W  = rfa_pkg::IN_WIDTH;
  localparam int MW = rfa_pkg::MAG_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_COMB,
    ST_GCD_TWO,
    ST_GCD_ODD,
    ST_GCD_LOOP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } state_e;

  function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // control and output registers
  state_e                      state_q, state_d;
  logic                        out_valid_q, out_valid_d;
  logic [rfa_pkg::NUM_W-1:0]   out_num_q, out_num_d;
  logic [rfa_pkg::DEN_W-1:0]   out_den_q, out_den_d;
  rfa_pkg::status_e            out_stat_q, out_stat_d;

  // datapath registers
  rfa_pkg::cmd_e               cmd_q, cmd_d;
  logic [W-1:0]                na_q, na_d, da_q, da_d, nb_q, nb_d, db_q, db_d;
  logic                        sa_q, sa_d, sb_q, sb_d;
  rfa_pkg::mag_t               p1_q, p1_d, p2_q, p2_d;
  rfa_pkg::mag_t               mag_q, mag_d, den_q, den_d;
  logic                        neg_q, neg_d;
  rfa_pkg::mag_t               u_q, u_d, v_q, v_d, g_q, g_d;
  logic [rfa_pkg::K_W-1:0]     k_q, k_d;
  rfa_pkg::status_e            stat_q, stat_d;

  // combinational helpers
  logic [W-1:0]                mul_a, mul_b;
  rfa_pkg::mag_t               mul_p;
  logic                        s2;
  rfa_pkg::mag_t               sum, absdiff, comb_mag;
  logic [MW:0]                 diff, vmu;
  logic                        comb_neg;
  logic [rfa_pkg::EXT_W-1:0]   ext_mag, ext_num, ext_den;
  logic                        in_fire;

  rfa_pkg::div_req_t           div_req;
  rfa_pkg::div_rsp_t           div_rsp;

  rfa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // shared multiplier operand select
  always_comb begin
    mul_a = na_q;
    mul_b = db_q;
    case (state_q)
      ST_MUL1: begin
        mul_a = na_q;
        mul_b = (cmd_q == rfa_pkg::CMD_MUL) ? nb_q : db_q;
      end
      ST_MUL2: begin
        mul_a = nb_q;
        mul_b = da_q;
      end
      ST_MUL3: begin
        mul_a = da_q;
        mul_b = (cmd_q == rfa_pkg::CMD_DIV) ? nb_q : db_q;
      end
      default: begin
        mul_a = na_q;
        mul_b = db_q;
      end
    endcase
    mul_p = rfa_pkg::mag_t'(mul_a) * rfa_pkg::mag_t'(mul_b);
  end

  // signed combine of the two cross products for add and subtract; multiply and divide pass the first product
  always_comb begin
    s2      = (cmd_q == rfa_pkg::CMD_SUB) ? !sb_q : sb_q;
    sum     = p1_q + p2_q;
    diff    = {1'b0, p1_q} - {1'b0, p2_q};
    absdiff = diff[MW] ? (p2_q - p1_q) : diff[MW-1:0];
    if (cmd_q == rfa_pkg::CMD_ADD || cmd_q == rfa_pkg::CMD_SUB) begin
      if (sa_q == s2) begin
        comb_mag = sum;
        comb_neg = sa_q;
      end else begin
        comb_mag = absdiff;
        comb_neg = diff[MW] ? s2 : sa_q;
      end
    end else begin
      comb_mag = p1_q;
      comb_neg = sa_q ^ sb_q;
    end
  end

  assign vmu     = {1'b0, v_q} - {1'b0, u_q};
  assign ext_mag = rfa_pkg::EXT_W'(mag_q);
  assign ext_num = neg_q ? (~ext_mag + 1'b1) : ext_mag;
  assign ext_den = rfa_pkg::EXT_W'(den_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_num_d   = out_num_q;
    out_den_d   = out_den_q;
    out_stat_d  = out_stat_q;

    cmd_d  = cmd_q;
    na_d   = na_q;
    da_d   = da_q;
    nb_d   = nb_q;
    db_d   = db_q;
    sa_d   = sa_q;
    sb_d   = sb_q;
    p1_d   = p1_q;
    p2_d   = p2_q;
    mag_d  = mag_q;
    den_d  = den_q;
    neg_d  = neg_q;
    u_d    = u_q;
    v_d    = v_q;
    g_d    = g_q;
    k_d    = k_q;
    stat_d = stat_q;

    div_req.start      = 1'b0;
    div_req.dividend_a = mag_q;
    div_req.dividend_b = den_q;
    div_req.divisor    = g_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d = rfa_pkg::cmd_e'(in_i.cmd);
          na_d  = magnitude(in_i.num_a);
          da_d  = magnitude(in_i.den_a);
          nb_d  = magnitude(in_i.num_b);
          db_d  = magnitude(in_i.den_b);
          sa_d  = in_i.num_a[W-1] ^ in_i.den_a[W-1];
          sb_d  = in_i.num_b[W-1] ^ in_i.den_b[W-1];
          mag_d = '0;
          den_d = '0;
          neg_d = 1'b0;
          if (in_i.den_a == '0 || in_i.den_b == '0) begin
            stat_d  = rfa_pkg::STATUS_ZERO_DEN;
            state_d = ST_FINISH;
          end else if (in_i.cmd == rfa_pkg::CMD_DIV && in_i.num_b == '0) begin
            stat_d  = rfa_pkg::STATUS_DIV_ZERO;
            state_d = ST_FINISH;
          end else begin
            stat_d  = rfa_pkg::STATUS_OK;
            state_d = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        p1_d    = mul_p;
        state_d = (cmd_q == rfa_pkg::CMD_ADD || cmd_q == rfa_pkg::CMD_SUB) ? ST_MUL2
                                                                          : ST_MUL3;
      end
      ST_MUL2: begin
        p2_d    = mul_p;
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        den_d   = mul_p;
        state_d = ST_COMB;
      end
      ST_COMB: begin
        if (comb_mag == '0) begin
          // zero result: give 0/1 and skip the reduction
          mag_d   = '0;
          den_d   = rfa_pkg::mag_t'(1);
          neg_d   = 1'b0;
          state_d = ST_FINISH;
        end else begin
          mag_d   = comb_mag;
          neg_d   = comb_neg;
          u_d     = comb_mag;
          v_d     = den_q;
          k_d     = '0;
          state_d = ST_GCD_TWO;
        end
      end
      ST_GCD_TWO: begin
        // strip common factors of two, count them in k
        if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 1'b1;
        end else begin
          state_d = ST_GCD_ODD;
        end
      end
      ST_GCD_ODD: begin
        if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else begin
          state_d = ST_GCD_LOOP;
        end
      end
      ST_GCD_LOOP: begin
        // u stays odd; v shrinks by halving or by subtracting u, or u and v swap roles when v < u
        if (v_q == '0) begin
          g_d     = u_q << k_q;
          state_d = ST_DIV_START;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (!vmu[MW]) begin
          v_d = vmu[MW-1:0];
        end else begin
          u_d = v_q;
          v_d = u_q - v_q;
        end
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          mag_d   = div_rsp.quot_a;
          den_d   = div_rsp.quot_b;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_num_d   = ext_num[rfa_pkg::NUM_W-1:0];
          out_den_d   = ext_den[rfa_pkg::DEN_W-1:0];
          out_stat_d  = stat_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_num_q   <= '0;
      out_den_q   <= '0;
      out_stat_q  <= rfa_pkg::STATUS_OK;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_num_q   <= out_num_d;
      out_den_q   <= out_den_d;
      out_stat_q  <= out_stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    na_q   <= na_d;
    da_q   <= da_d;
    nb_q   <= nb_d;
    db_q   <= db_d;
    sa_q   <= sa_d;
    sb_q   <= sb_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    mag_q  <= mag_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    u_q    <= u_d;
    v_q    <= v_d;
    g_q    <= g_d;
    k_q    <= k_d;
    stat_q <= stat_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.num_out = out_num_q;
  assign out_o.den_out = out_den_q;
  assign out_o.status  = out_stat_q;

  a_ok_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == rfa_pkg::STATUS_OK) |-> (out_o.den_out != '0))
    else $error("ok result with zero denominator");

  a_err_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != rfa_pkg::STATUS_OK)
      |-> (out_o.num_out == '0) && (out_o.den_out == '0))
    else $error("error result with nonzero fields");

  a_zero_is_unit_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == rfa_pkg::STATUS_OK && out_o.num_out == '0)
      |-> (out_o.den_out == rfa_pkg::DEN_W'(1)))
    else $error("zero result not given as 0/1");

  a_gcd_u_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GCD_LOOP) |-> u_q[0])
    else $error("gcd loop entered with even u");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the rational fraction ALU: directed table, then random fractions.
`timescale 1ns / 100ps

module tb;

  // Idle cycles in a row, with nothing taken on either side, that end the run.
  localparam int STALL_LIMIT  = 5000;
  // Cycles to wait after the last result has been taken, before the verdict.
  localparam int DRAIN_CYCLES = 250;
  localparam int RANDOM_ITEMS = 1325;
  // Beat numbers that place the pressure events and the quiet window, and the length of the ready hold in cycles.
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int PAUSE_AT     = 500;
  localparam int QUIET_FROM   = 700;
  localparam int QUIET_TO     = 900;

  typedef logic signed [rfa_pkg::IN_WIDTH-1:0] field_t;

  typedef struct packed {
    rfa_pkg::cmd_e cmd;
    field_t        num_a;
    field_t        den_a;
    field_t        num_b;
    field_t        den_b;
  } frac_op_t;

  typedef struct packed {
    logic signed [rfa_pkg::NUM_W-1:0] num;
    logic        [rfa_pkg::DEN_W-1:0] den;
    rfa_pkg::status_e                 status;
  } frac_res_t;

  typedef struct {
    frac_op_t  op;
    bit        spelled;
    frac_res_t want;
  } op_row_t;

  logic clk;
  logic rst_n;

  rfa_in_if  in_bus ();
  rfa_out_if out_bus ();

  rational_fraction_alu u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  frac_res_t reduced_q[$];
  op_row_t   op_table[$];
  int        beats_in;
  int        beats_out;
  int        mismatches;
  int        cmd_seen[4];
  int        status_seen[4];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Magnitude of a two's complement field; the most negative value maps to 2^(IN_WIDTH-1).
  function automatic longint unsigned field_mag(field_t v);
    return (v < 0) ? longint'(-longint'(v)) : longint'(v);
  endfunction

  // Exact rational result in lowest terms, worked on sign and magnitude so nothing wraps.
  function automatic frac_res_t reduce_fraction(frac_op_t op);
    longint unsigned ma, mda, mb, mdb;
    longint unsigned t1, t2, mag, den, x, y, r;
    bit              sa, sb, s2, neg;
    frac_res_t       res;
    ma  = field_mag(op.num_a);
    mda = field_mag(op.den_a);
    mb  = field_mag(op.num_b);
    mdb = field_mag(op.den_b);
    sa  = op.num_a[rfa_pkg::IN_WIDTH-1] ^ op.den_a[rfa_pkg::IN_WIDTH-1];
    sb  = op.num_b[rfa_pkg::IN_WIDTH-1] ^ op.den_b[rfa_pkg::IN_WIDTH-1];
    res = '0;
    res.status = rfa_pkg::STATUS_OK;
    // A zero denominator wins over a divide by a zero fraction.
    if (mda == 0 || mdb == 0) begin
      res.status = rfa_pkg::STATUS_ZERO_DEN;
      return res;
    end
    if (op.cmd == rfa_pkg::CMD_DIV && mb == 0) begin
      res.status = rfa_pkg::STATUS_DIV_ZERO;
      return res;
    end
    case (op.cmd)
      rfa_pkg::CMD_ADD, rfa_pkg::CMD_SUB: begin
        t1  = ma * mdb;
        t2  = mb * mda;
        s2  = (op.cmd == rfa_pkg::CMD_SUB) ? !sb : sb;
        den = mda * mdb;
        if (sa == s2) begin
          mag = t1 + t2;
          neg = sa;
        end else if (t1 >= t2) begin
          mag = t1 - t2;
          neg = sa;
        end else begin
          mag = t2 - t1;
          neg = s2;
        end
      end
      rfa_pkg::CMD_MUL: begin
        mag = ma * mb;
        den = mda * mdb;
        neg = sa ^ sb;
      end
      default: begin
        mag = ma * mdb;
        den = mda * mb;
        neg = sa ^ sb;
      end
    endcase
    // Zero comes out as 0/1 whatever the denominator was.
    if (mag == 0) begin
      res.den = 1;
      return res;
    end
    x = mag;
    y = den;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    mag = mag / x;
    den = den / x;
    res.num = rfa_pkg::NUM_W'(neg ? -longint'(mag) : longint'(mag));
    res.den = rfa_pkg::DEN_W'(den);
    return res;
  endfunction

  // Full-range values for the largest share, with small, medium, extreme and power-of-two values mixed in.
  function automatic field_t pick_field();
    int     sel;
    field_t v;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: v = field_t'($urandom);
      4, 5, 6:    v = field_t'(int'($urandom_range(0, 32)) - 16);
      7: begin
        case ($urandom_range(0, 4))
          0:       v = {1'b1, {(rfa_pkg::IN_WIDTH-1){1'b0}}};
          1:       v = {1'b0, {(rfa_pkg::IN_WIDTH-1){1'b1}}};
          2:       v = field_t'(-1);
          3:       v = field_t'(1);
          default: v = '0;
        endcase
      end
      8: begin
        v = field_t'(1) << $urandom_range(0, rfa_pkg::IN_WIDTH - 2);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = field_t'(int'($urandom_range(0, 600)) - 300);
    endcase
    return v;
  endfunction

  task automatic add_row(rfa_pkg::cmd_e c, int na, int da, int nb, int db, bit spelled,
                         longint wnum, longint wden, rfa_pkg::status_e wstat);
    op_row_t row;
    row.op.cmd       = c;
    row.op.num_a     = field_t'(na);
    row.op.den_a     = field_t'(da);
    row.op.num_b     = field_t'(nb);
    row.op.den_b     = field_t'(db);
    row.spelled      = spelled;
    row.want.num     = rfa_pkg::NUM_W'(wnum);
    row.want.den     = rfa_pkg::DEN_W'(wden);
    row.want.status  = wstat;
    op_table.push_back(row);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("[%0t] result %0d: %s got %0d want %0d", $realtime, beats_out, what, got, want);
  endtask

  function automatic bit sender_quiet();
    return beats_in >= QUIET_FROM && beats_in < QUIET_TO;
  endfunction

  // Offer one beat, with random idle cycles ahead of it; record the expected result on accept.
  task automatic drive_fraction(frac_op_t op, frac_res_t want);
    while (!sender_quiet() && $urandom_range(0, 99) < 7) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.cmd   <= op.cmd;
    in_bus.num_a <= op.num_a;
    in_bus.den_a <= op.den_a;
    in_bus.num_b <= op.num_b;
    in_bus.den_b <= op.den_b;
    do @(posedge clk); while (!in_bus.ready);
    reduced_q.push_back(want);
    cmd_seen[op.cmd]++;
    beats_in++;
  endtask

  // Stimulus: reset, directed table, random fractions, drain, verdict.
  initial begin
    frac_op_t op;
    rst_n        <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.cmd   <= rfa_pkg::CMD_ADD;
    in_bus.num_a <= '0;
    in_bus.den_a <= '0;
    in_bus.num_b <= '0;
    in_bus.den_b <= '0;

    // A zero sum, then error codes: zero denominators (checked ahead of divide) and divide by a zero fraction.
    add_row(rfa_pkg::CMD_ADD, 0, 1, 0, 1, 1, 0, 1, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_ADD, 1, 0, 1, 1, 1, 0, 0, rfa_pkg::STATUS_ZERO_DEN);
    add_row(rfa_pkg::CMD_SUB, 1, 1, 1, 0, 1, 0, 0, rfa_pkg::STATUS_ZERO_DEN);
    add_row(rfa_pkg::CMD_MUL, 0, 0, 5, 0, 1, 0, 0, rfa_pkg::STATUS_ZERO_DEN);
    add_row(rfa_pkg::CMD_DIV, 1, 0, 0, 1, 1, 0, 0, rfa_pkg::STATUS_ZERO_DEN);
    add_row(rfa_pkg::CMD_DIV, 3, 4, 0, -5, 1, 0, 0, rfa_pkg::STATUS_DIV_ZERO);
    // Extremes: most negative and most positive operands; the most negative give the widest numerator and denominator.
    add_row(rfa_pkg::CMD_MUL, -32768, 1, -32768, 1, 1, 1073741824, 1, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_ADD, -32768, 1, -32768, 1, 1, -65536, 1, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_DIV, -32768, 1, 1, -32768, 1, 1073741824, 1, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_MUL, 1, -32768, 1, -32768, 1, 1, 1073741824, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_MUL, 1, 32767, -1, -32768, 0, 0, 0, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_ADD, 32767, 1, 32767, 1, 1, 65534, 1, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_SUB, -32768, 1, 32767, 1, 1, -65535, 1, rfa_pkg::STATUS_OK);
    // Sign moves to the numerator and zero results come out as 0/1; further mixed rows follow.
    add_row(rfa_pkg::CMD_ADD, 3, -6, 0, 5, 1, -1, 2, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_SUB, 5, 7, 5, 7, 1, 0, 1, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_DIV, 0, 5, 3, 7, 1, 0, 1, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_MUL, 0, -1, 5, 5, 1, 0, 1, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_ADD, -32768, -32768, 32767, 32767, 1, 2, 1, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_ADD, -32768, 32767, -32768, -32767, 1, 0, 1, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_ADD, 1, 2, 1, 3, 0, 0, 0, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_SUB, 1, 3, 1, 2, 0, 0, 0, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_MUL, 6, -4, -2, 3, 0, 0, 0, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_DIV, 2, 3, -4, 9, 0, 0, 0, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_SUB, -1, 32767, 1, -32768, 0, 0, 0, rfa_pkg::STATUS_OK);
    add_row(rfa_pkg::CMD_DIV, 32767, -32768, -32768, 32767, 0, 0, 0, rfa_pkg::STATUS_OK);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (op_table[i])
      drive_fraction(op_table[i].op,
                     op_table[i].spelled ? op_table[i].want : reduce_fraction(op_table[i].op));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Once, drop valid and hold until every outstanding result has been taken.
      if (beats_in == PAUSE_AT) begin
        in_bus.valid <= 1'b0;
        do @(posedge clk); while (reduced_q.size() != 0);
      end
      op.cmd   = rfa_pkg::cmd_e'($urandom_range(0, 3));
      op.num_a = pick_field();
      op.den_a = pick_field();
      op.num_b = pick_field();
      op.den_b = pick_field();
      drive_fraction(op, reduce_fraction(op));
    end
    in_bus.valid <= 1'b0;

    while (reduced_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d beats: add %0d, sub %0d, mul %0d, div %0d",
             beats_in, cmd_seen[rfa_pkg::CMD_ADD], cmd_seen[rfa_pkg::CMD_SUB],
             cmd_seen[rfa_pkg::CMD_MUL], cmd_seen[rfa_pkg::CMD_DIV]);
    $display("results %0d: reduced %0d, zero denominator %0d, divide by zero %0d",
             beats_out, status_seen[rfa_pkg::STATUS_OK],
             status_seen[rfa_pkg::STATUS_ZERO_DEN], status_seen[rfa_pkg::STATUS_DIV_ZERO]);
    if (mismatches == 0) begin
      $display("rational_fraction_alu: match");
    end else begin
      $display("rational_fraction_alu: mismatch");
    end
    $finish;
  end

  // Result side: check each taken beat against the oldest expectation, then pick next ready.
  initial begin
    frac_res_t got;
    frac_res_t want;
    int        hold_left;
    bit        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_bus.valid && out_bus.ready) begin
        got.num    = out_bus.num_out;
        got.den    = out_bus.den_out;
        got.status = rfa_pkg::status_e'(out_bus.status);
        if (reduced_q.size() == 0) begin
          report_mismatch("unexpected beat, num", longint'(got.num), 0);
        end else begin
          want = reduced_q.pop_front();
          if (got.num !== want.num)
            report_mismatch("num_out", longint'(got.num), longint'(want.num));
          if (got.den !== want.den)
            report_mismatch("den_out", longint'(got.den), longint'(want.den));
          if (got.status !== want.status)
            report_mismatch("status", longint'(got.status), longint'(want.status));
        end
        status_seen[got.status]++;
        beats_out++;
      end
      // Once, hold ready low long enough for the block to fill and stall its input.
      if (!hold_done && beats_in >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (sender_quiet()) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= 7);
      end
      @(posedge clk);
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("timeout after %0d idle cycles, %0d results pending",
                   idle_cycles, reduced_q.size());
          $display("rational_fraction_alu: mismatch");
          $finish;
        end
      end
    end
  end

endmodule

// ----- files.f -----
hw/rtl/rfa_pkg.sv
hw/rtl/rfa_in_if.sv
hw/rtl/rfa_out_if.sv
hw/rtl/rfa_div.sv
hw/rtl/rational_fraction_alu.sv
dv/tb.sv
